// ----- hdl/dq_pkg.sv -----
// Package for the double-ended queue: depth, field widths, operation and
// status codes, and the cell and control structs.
// No dependencies.
package dq_pkg;

  localparam int DEPTH   = 16;
  localparam int DATA_W  = 32;
  localparam int KIND_W  = 3;
  localparam int COUNT_W = $clog2(DEPTH + 1);
  localparam int STAT_W  = 2;

  // Operation codes; unused codes behave as a peek
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_PEEK       = 3'd4;

  // Status codes
  localparam logic [STAT_W-1:0] STATUS_DONE      = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_POP_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_PUSH_FULL = 2'd2;

  localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

  // Contents of one cell
  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] data;
  } cell_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic shift_right;  // push at front
    logic shift_left;   // pop at front
    logic append;       // push at back
    logic trim;         // pop at back
  } cell_ctl_t;

endpackage

// ----- hdl/dq_if.sv -----
// Valid/ready channel interfaces for the queue request and response.
// Depends on dq_pkg.
interface dq_req_if import dq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [DATA_W-1:0] push_value;

  modport source (output valid, kind, push_value, input ready);
  modport sink (input valid, kind, push_value, output ready);
endinterface

interface dq_rsp_if import dq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] front_value;
  logic signed [DATA_W-1:0] back_value;
  logic [COUNT_W-1:0]       entry_count;
  logic [STAT_W-1:0]        status;

  modport source (output valid, front_value, back_value, entry_count, status, input ready);
  modport sink (input valid, front_value, back_value, entry_count, status, output ready);
endinterface

// ----- hdl/dq_cell.sv -----
// One queue cell: a valid flag and a data word, fed from its neighbors.
// Cell 0 is the front of the queue. Depends on dq_pkg.
module dq_cell import dq_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  cell_ctl_t                ctl,
  input  logic signed [DATA_W-1:0] push_value,
  input  cell_t                    left,
  input  cell_t                    right,
  output cell_t                    cur,
  output cell_t                    nxt
);

  cell_t slot;
  cell_t slot_next;

  // Next contents from the broadcast command
  always_comb begin
    slot_next = slot;
    if (ctl.shift_right) begin
      slot_next = left;
    end else if (ctl.shift_left) begin
      slot_next = right;
    end else if (ctl.append) begin
      if (!slot.valid && left.valid) begin
        slot_next.valid = 1'b1;
        slot_next.data  = push_value;
      end
    end else if (ctl.trim) begin
      if (slot.valid && !right.valid) begin
        slot_next.valid = 1'b0;
      end
    end
  end

  // Valid flag resets; data does not
  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid <= 1'b0;
    end else begin
      slot.valid <= slot_next.valid;
    end
    slot.data <= slot_next.data;
  end

  assign cur = slot;
  assign nxt = slot_next;

endmodule

// ----- hdl/double_ended_queue_unit.sv -----
// Double-ended queue built as a row of DEPTH shifting cells, front at cell 0.
// The response is registered and appears in the cycle after the request transaction.
// Throughput: one transaction per cycle while the response is taken; the response register is reloaded
// in the cycle it is taken. Reset clears all cell valid flags, the count
// and the response valid; no clearing pass. Depends on dq_pkg, dq_if, dq_cell.
module double_ended_queue_unit import dq_pkg::*; (
  input logic     clk,
  input logic     rst,
  dq_req_if.sink  req,
  dq_rsp_if.source rsp
);

  cell_t     cur [DEPTH];
  cell_t     nxt [DEPTH];
  cell_ctl_t ctl;

  logic               fire;
  logic               full;
  logic               empty;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic [STAT_W-1:0]  status_next;
  logic signed [DATA_W-1:0] front_next;
  logic signed [DATA_W-1:0] back_next;

  logic                     out_valid;
  logic signed [DATA_W-1:0] out_front;
  logic signed [DATA_W-1:0] out_back;
  logic [COUNT_W-1:0]       out_count;
  logic [STAT_W-1:0]        out_status;

  assign req.ready = !out_valid || rsp.ready;
  assign fire      = req.valid && req.ready;
  assign full      = cur[DEPTH-1].valid;
  assign empty     = !cur[0].valid;

  // Decode the transaction into a cell command, count and status
  always_comb begin
    ctl         = '0;
    count_next  = count;
    status_next = STATUS_DONE;
    case (req.kind)
      KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
        if (full) begin
          status_next = STATUS_PUSH_FULL;
        end else begin
          ctl.append      = fire && (req.kind == KIND_PUSH_BACK);
          ctl.shift_right = fire && (req.kind == KIND_PUSH_FRONT);
          count_next      = count + COUNT_W'(1);
        end
      end
      KIND_POP_FRONT, KIND_POP_BACK: begin
        if (empty) begin
          status_next = STATUS_POP_EMPTY;
        end else begin
          ctl.shift_left = fire && (req.kind == KIND_POP_FRONT);
          ctl.trim       = fire && (req.kind == KIND_POP_BACK);
          count_next     = count - COUNT_W'(1);
        end
      end
      default: begin
        status_next = STATUS_DONE;
      end
    endcase
  end

  // Row of cells with neighbor links
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_t left_in;
    cell_t right_in;
    if (i == 0) begin : g_first
      assign left_in = '{valid: 1'b1, data: req.push_value};
    end else begin : g_mid_l
      assign left_in = cur[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_in = '{valid: 1'b0, data: '0};
    end else begin : g_mid_r
      assign right_in = cur[i+1];
    end
    dq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .push_value (req.push_value),
      .left       (left_in),
      .right      (right_in),
      .cur        (cur[i]),
      .nxt        (nxt[i])
    );
  end

  // Front and back after the operation; back is the last valid cell
  always_comb begin
    logic is_last;
    front_next = nxt[0].valid ? nxt[0].data : EMPTY_VALUE;
    back_next  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (i == DEPTH - 1) begin
        is_last = nxt[i].valid;
      end else begin
        is_last = nxt[i].valid && !nxt[(i + 1) % DEPTH].valid;
      end
      if (is_last) begin
        back_next = back_next | nxt[i].data;
      end
    end
    if (!nxt[0].valid) begin
      back_next = EMPTY_VALUE;
    end
  end

  // Count register
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (fire) begin
      count <= count_next;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (fire) begin
      out_front  <= front_next;
      out_back   <= back_next;
      out_count  <= count_next;
      out_status <= status_next;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.front_value = out_front;
  assign rsp.back_value  = out_back;
  assign rsp.entry_count = out_count;
  assign rsp.status      = out_status;

endmodule

// ----- hdl/dq_checker.sv -----
// Port-level checks for the double-ended queue, bound to the top level.
// Depends on dq_pkg and double_ended_queue_unit.
module dq_checker import dq_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     rsp_valid,
  input logic signed [DATA_W-1:0] front_value,
  input logic signed [DATA_W-1:0] back_value,
  input logic [COUNT_W-1:0]       entry_count,
  input logic [STAT_W-1:0]        status
);

  // No response right after reset
  a_reset_clear: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // Count never exceeds the depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> entry_count <= COUNT_W'(DEPTH))
    else $error("entry count above depth");

  // Empty queue reports the empty marker on both ends
  a_empty_marker: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && entry_count == '0 |->
      front_value == EMPTY_VALUE && back_value == EMPTY_VALUE)
    else $error("empty queue shows a value");

  // A single entry is both front and back
  a_single: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && entry_count == COUNT_W'(1) |-> front_value == back_value)
    else $error("single entry front and back differ");

  // Error status only at the matching boundary
  a_status_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |->
      (status != STATUS_POP_EMPTY || entry_count == '0) &&
      (status != STATUS_PUSH_FULL || entry_count == COUNT_W'(DEPTH)))
    else $error("error status away from boundary");

endmodule

bind double_ended_queue_unit dq_checker u_dq_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .front_value (rsp.front_value),
  .back_value  (rsp.back_value),
  .entry_count (rsp.entry_count),
  .status      (rsp.status)
);
